### sv/priority_task_scheduler_top_defines.svh
// Assertion macros shared by the scheduler RTL.
`ifndef PRIORITY_TASK_SCHEDULER_TOP_DEFINES_SVH
`define PRIORITY_TASK_SCHEDULER_TOP_DEFINES_SVH

// Clocked assertion, masked while reset is applied.
`define PS_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen.
`define PS_ASSERT_NEVER(lbl, expr, msg) \
  `PS_ASSERT_CLK(lbl, !(expr), msg)

`endif

### sv/psched_pkg.sv
// Types and constants for the priority task scheduler.
`timescale 1ns / 1ps

package psched_pkg;

  localparam int DEF_PRIO_SLOTS = 32;
  localparam int DEF_DELAY_BITS = 16;
  localparam logic [7:0] LOCK_MAX = 8'hFF;

  typedef enum logic [2:0] {
    ACT_TICK     = 3'd0,
    ACT_DELAY    = 3'd1,
    ACT_LOCK     = 3'd2,
    ACT_UNLOCK   = 3'd3,
    ACT_CREATE   = 3'd4,
    ACT_SCHEDULE = 3'd5
  } act_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [4:0]  slot_prio;
    logic [15:0] delay_ticks;
  } sched_req_t;

  typedef struct packed {
    logic       switched;
    logic [4:0] running_prio;
    logic       running_valid;
    logic       none_ready;
    logic [7:0] lock_level;
  } sched_res_t;

  typedef struct packed {
    logic tick;
    logic create;
    logic delay;
  } cell_cmd_t;

endpackage

### sv/psched_cell.sv
// One priority slot: delay counter, present and ready bits, and a stage of the pick chain.
`timescale 1ns / 1ps

module psched_cell
  import psched_pkg::*;
#(
  parameter int DELAY_BITS = DEF_DELAY_BITS,
  parameter int IDX_W      = 5,
  parameter int IDX        = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_cmd_t             cmd_i,
  input  logic [4:0]            slot_prio_i,
  input  logic [IDX_W-1:0]      cur_slot_i,
  input  logic [DELAY_BITS-1:0] delay_val_i,
  input  logic                  scan_i,
  input  logic                  found_i,
  input  logic [IDX_W-1:0]      idx_i,
  output logic                  scan_o,
  output logic                  found_o,
  output logic [IDX_W-1:0]      idx_o
);

  localparam int CW = (IDX_W > 5) ? IDX_W : 5;

  logic [DELAY_BITS-1:0] cnt_q, cnt_d;
  logic                  pres_q, pres_d;
  logic                  rdy_q, rdy_d;
  logic                  scan_q, found_q;
  logic [IDX_W-1:0]      idx_q;
  logic                  create_hit, delay_hit;

  assign create_hit = (CW'(slot_prio_i) == CW'(IDX));
  assign delay_hit  = (cur_slot_i == IDX_W'(IDX));

  always_comb begin
    cnt_d  = cnt_q;
    pres_d = pres_q;
    rdy_d  = rdy_q;
    if (cmd_i.tick && pres_q) begin
      if (cnt_q != '0) begin
        cnt_d = cnt_q - DELAY_BITS'(1);
      end else begin
        rdy_d = 1'b1;
      end
    end
    if (cmd_i.create && create_hit) begin
      cnt_d  = '0;
      pres_d = 1'b1;
      rdy_d  = 1'b1;
    end
    if (cmd_i.delay && delay_hit) begin
      cnt_d = delay_val_i;
      rdy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      pres_q  <= 1'b0;
      rdy_q   <= 1'b0;
      scan_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      pres_q  <= pres_d;
      rdy_q   <= rdy_d;
      scan_q  <= scan_i;
      found_q <= found_i | (scan_i & rdy_q);
    end
  end

  // first ready slot along the chain wins
  always_ff @(posedge clk_i) begin
    idx_q <= found_i ? idx_i : IDX_W'(IDX);
  end

  assign scan_o  = scan_q;
  assign found_o = found_q;
  assign idx_o   = idx_q;

endmodule

### sv/priority_task_scheduler_top.sv
// Priority task scheduler: action decode, lock count, running task and a chain of slot cells.
// Lock, create and idle codes, and picks held off by the lock: result strobe in the cycle after
// the request, next request at once. Tick, delay, schedule and an unlock to zero with lock at
// zero: the pick token walks the cell chain one slot per cycle, from scan_go_q through each
// cell's register; the result is registered as it leaves the last cell, and busy is high meanwhile.
// Reset is asynchronous and clears every slot, the lock count and the running task.
`timescale 1ns / 1ps
`include "priority_task_scheduler_top_defines.svh"

module priority_task_scheduler_top
  import psched_pkg::*;
#(
  parameter int PRIO_SLOTS = DEF_PRIO_SLOTS,
  parameter int DELAY_BITS = DEF_DELAY_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  sched_req_t req_i,
  output logic       busy,
  output logic       res_valid_o,
  output sched_res_t res_o
);

  localparam int IDX_W = $clog2(PRIO_SLOTS);
  localparam int CMP_W = (DELAY_BITS > 16) ? DELAY_BITS : 16;

  state_e            state_q, state_d;
  logic [7:0]        lock_q, lock_d;
  logic [IDX_W-1:0]  cur_q, cur_d;
  logic              cur_valid_q, cur_valid_d;
  logic              scan_go_q;
  logic              res_valid_q, res_valid_d;
  sched_res_t        res_q, res_d;

  logic              accept;
  logic              pick_req;
  logic              scan_start;
  logic              scan_done;
  cell_cmd_t         cmd;
  logic [CMP_W-1:0]  ticks_ext;
  logic [CMP_W-1:0]  dmax_ext;
  logic [DELAY_BITS-1:0] delay_val;

  logic              scan_w  [0:PRIO_SLOTS];
  logic              found_w [0:PRIO_SLOTS];
  logic [IDX_W-1:0]  idx_w   [0:PRIO_SLOTS];

  assign accept = start & ~busy;

  assign ticks_ext = CMP_W'(req_i.delay_ticks);
  assign dmax_ext  = CMP_W'({DELAY_BITS{1'b1}});
  assign delay_val = (ticks_ext > dmax_ext) ? {DELAY_BITS{1'b1}} : DELAY_BITS'(ticks_ext);

  always_comb begin
    cmd      = '0;
    lock_d   = lock_q;
    pick_req = 1'b0;
    if (accept) begin
      unique case (req_i.action)
        ACT_TICK: begin
          cmd.tick = 1'b1;
          pick_req = 1'b1;
        end
        ACT_DELAY: begin
          cmd.delay = cur_valid_q;
          pick_req  = 1'b1;
        end
        ACT_LOCK: begin
          if (lock_q != LOCK_MAX) lock_d = lock_q + 8'd1;
        end
        ACT_UNLOCK: begin
          if (lock_q != 8'd0) begin
            lock_d   = lock_q - 8'd1;
            pick_req = (lock_q == 8'd1);
          end
        end
        ACT_CREATE: begin
          cmd.create = 1'b1;
        end
        ACT_SCHEDULE: begin
          pick_req = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign scan_start = pick_req && (lock_d == 8'd0);
  assign scan_done  = scan_w[PRIO_SLOTS];

  // cell chain
  assign scan_w[0]  = scan_go_q;
  assign found_w[0] = 1'b0;
  assign idx_w[0]   = '0;

  for (genvar k = 0; k < PRIO_SLOTS; k++) begin : g_cell
    psched_cell #(
      .DELAY_BITS(DELAY_BITS),
      .IDX_W     (IDX_W),
      .IDX       (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .slot_prio_i (req_i.slot_prio),
      .cur_slot_i  (cur_q),
      .delay_val_i (delay_val),
      .scan_i      (scan_w[k]),
      .found_i     (found_w[k]),
      .idx_i       (idx_w[k]),
      .scan_o      (scan_w[k+1]),
      .found_o     (found_w[k+1]),
      .idx_o       (idx_w[k+1])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (scan_start) state_d = ST_SCAN;
      ST_SCAN: if (scan_done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy = (state_q == ST_SCAN);
  end

  // running task and result
  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    res_d.switched   = 1'b0;
    res_d.none_ready = 1'b0;
    if (state_q == ST_SCAN && scan_done) begin
      res_valid_d = 1'b1;
      if (found_w[PRIO_SLOTS]) begin
        if (!cur_valid_q || cur_q != idx_w[PRIO_SLOTS]) begin
          cur_d          = idx_w[PRIO_SLOTS];
          cur_valid_d    = 1'b1;
          res_d.switched = 1'b1;
        end
      end else begin
        res_d.none_ready = 1'b1;
      end
    end else if (accept && !scan_start) begin
      res_valid_d = 1'b1;
    end
    res_d.running_prio  = cur_valid_d ? 5'(cur_d) : 5'd0;
    res_d.running_valid = cur_valid_d;
    res_d.lock_level    = lock_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lock_q      <= 8'd0;
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      scan_go_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lock_q      <= lock_d;
      cur_q       <= cur_d;
      cur_valid_q <= cur_valid_d;
      scan_go_q   <= scan_start;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `PS_ASSERT_CLK(a_res_not_busy, res_valid_q |-> !busy, "result strobe during a pick")
  `PS_ASSERT_NEVER(a_scan_out_idle, scan_done && state_q != ST_SCAN, "pick token outside scan")
  `PS_ASSERT_CLK(a_sw_valid, (res_valid_q && res_q.switched) |-> res_q.running_valid, "switch without running task")
  `PS_ASSERT_CLK(a_none_unlocked, (res_valid_q && res_q.none_ready) |-> (res_q.lock_level == 8'd0), "none ready while locked")

endmodule
